// ----- hw/rtl/key_event_debounce_modifiers_macros.svh -----
// Assertion macros shared by the key event debounce checker
`ifndef KEY_EVENT_DEBOUNCE_MODIFIERS_MACROS_SVH
`define KEY_EVENT_DEBOUNCE_MODIFIERS_MACROS_SVH

// same-cycle implication
`define KEDM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kedm assertion failed");

// next-cycle implication
`define KEDM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kedm assertion failed");

// condition that must never hold
`define KEDM_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("kedm assertion failed");

`endif

// ----- hw/rtl/kedm_pkg.sv -----
// Shared types and constants for the key event debounce block
package kedm_pkg;

    localparam int IN_W      = 46;
    localparam int KEY_W     = 6;
    localparam int CELL_KEYS = 8;
    localparam int CELL_IW   = 3;
    localparam int CFG_IW    = 1;
    localparam int CFG_DW    = 6;

    localparam logic [CFG_IW-1:0] REG_SHIFT_KEY = 1'b0;
    localparam logic [CFG_IW-1:0] REG_ALPHA_KEY = 1'b1;

    typedef struct packed {
        logic load;
        logic merge;
    } cell_ctl_t;

    typedef struct packed {
        logic shift;
        logic alpha;
        logic locked;
    } mod_state_t;

endpackage

// ----- hw/rtl/kedm_ifs.sv -----
// Request and result channel interfaces of the key event debounce block
interface kedm_in_if;
    logic                      valid;
    logic                      ready;
    logic [kedm_pkg::IN_W-1:0] keys_down;

    modport source (output valid, output keys_down, input ready);
    modport sink (input valid, input keys_down, output ready);
endinterface

interface kedm_out_if;
    logic                       valid;
    logic                       ready;
    logic [kedm_pkg::KEY_W-1:0] key_index;
    logic                       with_shift;
    logic                       with_alpha;
    logic                       shift_now;
    logic                       alpha_now;
    logic                       alpha_lock_now;

    modport source (output valid, output key_index, output with_shift, output with_alpha,
                    output shift_now, output alpha_now, output alpha_lock_now, input ready);
    modport sink (input valid, input key_index, input with_shift, input with_alpha,
                  input shift_now, input alpha_now, input alpha_lock_now, output ready);
endinterface

// ----- hw/rtl/kedm_cell.sv -----
// Debounce cell: seen-up mask for a group of keys and one link of the priority chain
module kedm_cell #(
    parameter int BASE = 0
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [kedm_pkg::CELL_KEYS-1:0]       down,
    input  kedm_pkg::cell_ctl_t                  ctl,
    input  logic                                 hit_in,
    input  logic [kedm_pkg::KEY_W-1:0]           idx_in,
    output logic                                 hit_out,
    output logic [kedm_pkg::KEY_W-1:0]           idx_out
);

    logic [kedm_pkg::CELL_KEYS-1:0] mask_reg;
    logic [kedm_pkg::CELL_KEYS-1:0] mask_next;
    logic [kedm_pkg::CELL_KEYS-1:0] hits;
    logic [kedm_pkg::CELL_IW-1:0]   lsb;

    always_comb
    begin
        if (ctl.load)
        begin
            mask_next = ~down;
        end
        else if (ctl.merge)
        begin
            mask_next = mask_reg | ~down;
        end
        else
        begin
            mask_next = mask_reg;
        end
    end

    assign hits = down & mask_reg;

    always_comb
    begin
        lsb = '0;
        for (int i = kedm_pkg::CELL_KEYS - 1; i >= 0; i--)
        begin
            if (hits[i])
            begin
                lsb = kedm_pkg::CELL_IW'(i);
            end
        end
    end

    assign hit_out = hit_in | (|hits);
    assign idx_out = (hit_in || !(|hits)) ? idx_in
                   : kedm_pkg::KEY_W'(BASE) + kedm_pkg::KEY_W'(lsb);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

endmodule

// ----- hw/rtl/kedm_modifier.sv -----
// Shift and alpha modifier state machine
module kedm_modifier (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       fire,
    input  logic [kedm_pkg::KEY_W-1:0] key,
    input  logic [kedm_pkg::KEY_W-1:0] shift_key,
    input  logic [kedm_pkg::KEY_W-1:0] alpha_key,
    output kedm_pkg::mod_state_t       cur,
    output kedm_pkg::mod_state_t       nxt
);

    kedm_pkg::mod_state_t mod_reg;

    always_comb
    begin
        nxt = mod_reg;
        if (key == shift_key)
        begin
            nxt.shift = !mod_reg.shift;
        end
        else if (key == alpha_key)
        begin
            if (mod_reg.locked)
            begin
                nxt.locked = 1'b0;
                nxt.alpha  = 1'b0;
            end
            else if (mod_reg.alpha)
            begin
                nxt.locked = 1'b1;
                nxt.alpha  = 1'b0;
            end
            else
            begin
                nxt.alpha = 1'b1;
            end
        end
        else
        begin
            nxt.shift = 1'b0;
            nxt.alpha = 1'b0;
        end
    end

    assign cur = mod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg <= '0;
        end
        else if (fire)
        begin
            mod_reg <= nxt;
        end
    end

endmodule

// ----- hw/rtl/key_event_debounce_modifiers.sv -----
// Key event debounce with sticky modifiers: top level
//
// Takes one key snapshot per clock and answers with at most one key event,
// registered, in the cycle after the snapshot is taken. The input is held off
// only while a finished event sits in the output register and is not taken.
// Snapshots run through capture, confirm and scan phases; the lowest newly
// pressed key is found by a carry chain through ceil(min(NUM_KEYS, 46)/8) cells
// of eight keys each, which sets the combinational depth of each snapshot step.
module key_event_debounce_modifiers #(
    parameter int NUM_KEYS = 46
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [kedm_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [kedm_pkg::CFG_DW-1:0]   cfg_data,
    kedm_in_if.sink                       keys,
    kedm_out_if.source                    result
);

    localparam int KEYS   = (NUM_KEYS < kedm_pkg::IN_W) ? NUM_KEYS : kedm_pkg::IN_W;
    localparam int NCELLS = (KEYS + kedm_pkg::CELL_KEYS - 1) / kedm_pkg::CELL_KEYS;
    localparam int PAD_W  = NCELLS * kedm_pkg::CELL_KEYS;

    typedef enum logic [1:0] {
        PH_CAPTURE,
        PH_CONFIRM,
        PH_SCAN
    } phase_t;

    phase_t                        phase_reg;
    phase_t                        phase_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [kedm_pkg::KEY_W-1:0]    key_reg;
    kedm_pkg::mod_state_t          was_reg;
    kedm_pkg::mod_state_t          now_reg;
    logic [kedm_pkg::KEY_W-1:0]    shift_key_reg;
    logic [kedm_pkg::KEY_W-1:0]    alpha_key_reg;

    logic                          accept;
    logic                          fire;
    logic                          any_hit;
    logic [kedm_pkg::KEY_W-1:0]    hit_key;
    logic [PAD_W-1:0]              down_pad;
    kedm_pkg::cell_ctl_t           ctl;
    kedm_pkg::mod_state_t          mod_cur;
    kedm_pkg::mod_state_t          mod_nxt;

    logic                          hit_c [NCELLS+1];
    logic [kedm_pkg::KEY_W-1:0]    idx_c [NCELLS+1];

    assign keys.ready = !out_valid_reg || result.ready;
    assign accept     = keys.valid && keys.ready;
    assign down_pad   = PAD_W'(keys.keys_down[KEYS-1:0]);

    assign hit_c[0] = 1'b0;
    assign idx_c[0] = '0;

    for (genvar c = 0; c < NCELLS; c++)
    begin : g_cell
        kedm_cell #(
            .BASE(c * kedm_pkg::CELL_KEYS)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .down    (down_pad[c*kedm_pkg::CELL_KEYS +: kedm_pkg::CELL_KEYS]),
            .ctl     (ctl),
            .hit_in  (hit_c[c]),
            .idx_in  (idx_c[c]),
            .hit_out (hit_c[c+1]),
            .idx_out (idx_c[c+1])
        );
    end

    assign any_hit = hit_c[NCELLS];
    assign hit_key = idx_c[NCELLS];

    assign fire      = accept && (phase_reg == PH_SCAN) && any_hit;
    assign ctl.load  = accept && (phase_reg == PH_CAPTURE || phase_reg == PH_CONFIRM);
    assign ctl.merge = accept && (phase_reg == PH_SCAN) && !any_hit;

    kedm_modifier u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .key       (hit_key),
        .shift_key (shift_key_reg),
        .alpha_key (alpha_key_reg),
        .cur       (mod_cur),
        .nxt       (mod_nxt)
    );

    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            case (phase_reg)
                PH_CAPTURE: phase_next = PH_CONFIRM;
                PH_CONFIRM: phase_next = PH_SCAN;
                PH_SCAN:    phase_next = any_hit ? PH_CAPTURE : PH_SCAN;
                default:    phase_next = PH_SCAN;
            endcase
        end
    end

    always_comb
    begin
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_CAPTURE;
            out_valid_reg <= 1'b0;
            key_reg       <= '0;
            was_reg       <= '0;
            now_reg       <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                key_reg <= hit_key;
                was_reg <= mod_cur;
                now_reg <= mod_nxt;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_key_reg <= kedm_pkg::KEY_W'(0);
            alpha_key_reg <= kedm_pkg::KEY_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                kedm_pkg::REG_SHIFT_KEY: shift_key_reg <= cfg_data;
                kedm_pkg::REG_ALPHA_KEY: alpha_key_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.key_index      = key_reg;
    assign result.with_shift     = was_reg.shift;
    assign result.with_alpha     = was_reg.alpha | was_reg.locked;
    assign result.shift_now      = now_reg.shift;
    assign result.alpha_now      = now_reg.alpha;
    assign result.alpha_lock_now = now_reg.locked;

endmodule

// ----- hw/rtl/kedm_checker.sv -----
// Port-level checks for the key event debounce block, bound to the top level
`include "key_event_debounce_modifiers_macros.svh"

module kedm_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [kedm_pkg::KEY_W-1:0] key_index,
    input logic                       with_shift,
    input logic                       with_alpha,
    input logic                       alpha_now,
    input logic                       alpha_lock_now
);

    // hold-off only while an event waits
    `KEDM_ASSERT_NOW(a_ready_only_when_full, !in_ready, out_valid)
    // a new event needs a request taken in the cycle before
    `KEDM_ASSERT_NOW(a_event_from_request, $rose(out_valid), $past(in_valid && in_ready))
    // alpha is never both active and locked
    `KEDM_ASSERT_NEVER(a_alpha_exclusive, out_valid && alpha_now && alpha_lock_now)
    `KEDM_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready,
                      out_valid && $stable(key_index) && $stable(with_shift)
                      && $stable(with_alpha))

endmodule

bind key_event_debounce_modifiers kedm_checker u_kedm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (keys.valid),
    .in_ready       (keys.ready),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .key_index      (result.key_index),
    .with_shift     (result.with_shift),
    .with_alpha     (result.with_alpha),
    .alpha_now      (result.alpha_now),
    .alpha_lock_now (result.alpha_lock_now)
);

// ----- tb/sv/tb_top.sv -----
// Testbench for key_event_debounce_modifiers: snapshot requests in, key events checked
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [kedm_pkg::KEY_W-1:0] key_index;
        logic                       with_shift;
        logic                       with_alpha;
        logic                       shift_now;
        logic                       alpha_now;
        logic                       alpha_lock_now;
    } key_event_t;

    typedef enum logic [1:0] {PH_CAPTURE, PH_CONFIRM, PH_SCAN} scan_phase_t;

    typedef struct {
        logic [kedm_pkg::IN_W-1:0] keys;
        bit                        typed;
        key_event_t                ev;
    } snap_row_t;

    localparam logic [kedm_pkg::IN_W-1:0] ALL_KEYS = '1;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_we;
    logic [kedm_pkg::CFG_IW-1:0]   cfg_index;
    logic [kedm_pkg::CFG_DW-1:0]   cfg_data;

    kedm_in_if  keys_if ();
    kedm_out_if event_if ();

    key_event_debounce_modifiers DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .keys      (keys_if),
        .result    (event_if)
    );

    always #6 clk = ~clk;

    // debounce and modifier state as the block should hold it
    logic [kedm_pkg::IN_W-1:0]  seen_up;
    scan_phase_t                phase;
    logic                       shift_on;
    logic                       alpha_on;
    logic                       alpha_lock;
    logic [kedm_pkg::KEY_W-1:0] shift_key;
    logic [kedm_pkg::KEY_W-1:0] alpha_key;

    key_event_t pending_events [$];
    int         fault_count = 0;
    int         sent_total = 0;
    int         hold_reqs = 0;
    bit         idle_on = 1'b1;
    bit         cur_typed = 1'b0;
    key_event_t cur_ev = '0;

    snap_row_t dir_rows [25] = '{
        '{46'h0, 1'b0, '0},
        '{46'h0, 1'b0, '0},
        '{46'h3FFF_FFFF_FFFF, 1'b1, '{6'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0}},
        '{46'h3FFF_FFFF_FFFF, 1'b0, '0},
        '{46'h0, 1'b0, '0},
        '{46'h2000_0000_0000, 1'b1, '{6'd45, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{46'h0, 1'b0, '0},
        '{46'h2, 1'b0, '0},
        '{46'h2, 1'b0, '0},
        '{46'h0, 1'b0, '0},
        '{46'h2, 1'b0, '0},
        '{46'h0, 1'b0, '0},
        '{46'h0, 1'b0, '0},
        '{46'h2, 1'b0, '0},
        '{46'h0, 1'b0, '0},
        '{46'h0, 1'b0, '0},
        '{46'h80, 1'b0, '0},
        '{46'h0, 1'b0, '0},
        '{46'h0, 1'b0, '0},
        '{46'h2, 1'b0, '0},
        '{46'h0, 1'b0, '0},
        '{46'h0, 1'b0, '0},
        '{46'h2AAA_AAAA_AAAA, 1'b0, '0},
        '{46'h1555_5555_5555, 1'b0, '0},
        '{46'h0, 1'b0, '0}
    };

    function automatic bit debounce_step(input logic [kedm_pkg::IN_W-1:0] down,
                                         output key_event_t ev);
        logic [kedm_pkg::IN_W-1:0]  up;
        logic [kedm_pkg::IN_W-1:0]  hits;
        logic [kedm_pkg::KEY_W-1:0] k;
        up = ~down;
        ev = '0;
        k = '0;
        if (phase == PH_CAPTURE)
        begin
            seen_up = up;
            phase = PH_CONFIRM;
            return 1'b0;
        end
        if (phase == PH_CONFIRM)
        begin
            seen_up &= up;
            phase = PH_SCAN;
        end
        hits = down & seen_up;
        if (hits == '0)
        begin
            seen_up |= up;
            return 1'b0;
        end
        for (int i = kedm_pkg::IN_W - 1; i >= 0; i--)
        begin
            if (hits[i])
                k = kedm_pkg::KEY_W'(i);
        end
        ev.key_index = k;
        ev.with_shift = shift_on;
        ev.with_alpha = alpha_on | alpha_lock;
        if (k == shift_key)
            shift_on = ~shift_on;
        else if (k == alpha_key)
        begin
            if (alpha_lock)
            begin
                alpha_lock = 1'b0;
                alpha_on = 1'b0;
            end
            else if (alpha_on)
            begin
                alpha_lock = 1'b1;
                alpha_on = 1'b0;
            end
            else
                alpha_on = 1'b1;
        end
        else
        begin
            shift_on = 1'b0;
            alpha_on = 1'b0;
        end
        ev.shift_now = shift_on;
        ev.alpha_now = alpha_on;
        ev.alpha_lock_now = alpha_lock;
        phase = PH_CAPTURE;
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic check_field(input string name, input logic [kedm_pkg::KEY_W-1:0] want,
                               input logic [kedm_pkg::KEY_W-1:0] got);
        if (got !== want)
        begin
            fault_count++;
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // results checked first, then the accepted request is predicted
    always @(posedge clk)
    begin
        key_event_t want;
        key_event_t got;
        key_event_t ev;
        if (rst_n)
        begin
            if (event_if.valid && event_if.ready)
            begin
                got = '{event_if.key_index, event_if.with_shift, event_if.with_alpha,
                        event_if.shift_now, event_if.alpha_now, event_if.alpha_lock_now};
                if (pending_events.size() == 0)
                begin
                    fault_count++;
                    $display("%0t ns: key event %0d with none expected", $time,
                             got.key_index);
                end
                else
                begin
                    want = pending_events.pop_front();
                    check_field("key_index", want.key_index, got.key_index);
                    check_field("with_shift", kedm_pkg::KEY_W'(want.with_shift),
                                kedm_pkg::KEY_W'(got.with_shift));
                    check_field("with_alpha", kedm_pkg::KEY_W'(want.with_alpha),
                                kedm_pkg::KEY_W'(got.with_alpha));
                    check_field("shift_now", kedm_pkg::KEY_W'(want.shift_now),
                                kedm_pkg::KEY_W'(got.shift_now));
                    check_field("alpha_now", kedm_pkg::KEY_W'(want.alpha_now),
                                kedm_pkg::KEY_W'(got.alpha_now));
                    check_field("alpha_lock_now", kedm_pkg::KEY_W'(want.alpha_lock_now),
                                kedm_pkg::KEY_W'(got.alpha_lock_now));
                end
            end
            if (keys_if.valid && keys_if.ready)
            begin
                if (debounce_step(keys_if.keys_down, ev) || cur_typed)
                    pending_events.push_back(cur_typed ? cur_ev : ev);
            end
        end
    end

    // result side: random stalls, plus a long hold-off on request
    initial
    begin
        int hold_left;
        int stall;
        int hold_seen;
        hold_left = 0;
        stall = 0;
        hold_seen = 0;
        event_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_seen != hold_reqs)
            begin
                hold_seen = hold_reqs;
                hold_left = 150;
            end
            if (hold_left > 0)
            begin
                event_if.ready <= 1'b0;
                hold_left--;
            end
            else if (stall > 0)
            begin
                event_if.ready <= 1'b0;
                stall--;
            end
            else
            begin
                event_if.ready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    task automatic send_snapshot(input logic [kedm_pkg::IN_W-1:0] kd, input bit typed = 1'b0,
                                 input key_event_t ev = '0);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            keys_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cur_typed = typed;
        cur_ev = ev;
        keys_if.valid <= 1'b1;
        keys_if.keys_down <= kd;
        do
            @(posedge clk);
        while (!keys_if.ready);
        sent_total++;
        @(negedge clk);
    endtask

    task automatic drain();
        keys_if.valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_modifier_keys(input logic [kedm_pkg::KEY_W-1:0] sk,
                                     input logic [kedm_pkg::KEY_W-1:0] ak);
        cfg_we <= 1'b1;
        cfg_index <= kedm_pkg::REG_SHIFT_KEY;
        cfg_data <= sk;
        @(negedge clk);
        cfg_index <= kedm_pkg::REG_ALPHA_KEY;
        cfg_data <= ak;
        @(negedge clk);
        cfg_we <= 1'b0;
        shift_key = sk;
        alpha_key = ak;
    endtask

    // mostly release-then-press sequences, some dense noise and edge patterns
    task automatic run_random(input int n, input bit with_hold);
        int                        first;
        int                        pick;
        int                        k;
        int                        extra;
        bit                        hold_done;
        logic [63:0]               w;
        logic [kedm_pkg::IN_W-1:0] held;
        first = sent_total;
        hold_done = 1'b0;
        while (sent_total - first < n)
        begin
            if (with_hold && !hold_done && sent_total - first >= n / 4)
            begin
                hold_reqs++;
                hold_done = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 65)
            begin
                w = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
                held = ($urandom_range(0, 1) == 1) ? w[kedm_pkg::IN_W-1:0] : '0;
                pick = $urandom_range(0, 99);
                if (pick < 35 && shift_key < kedm_pkg::IN_W)
                    k = int'(shift_key);
                else if (pick < 60 && alpha_key < kedm_pkg::IN_W)
                    k = int'(alpha_key);
                else
                    k = $urandom_range(0, kedm_pkg::IN_W - 1);
                send_snapshot(held);
                // occasional bounce during confirm
                if ($urandom_range(0, 9) == 0)
                    send_snapshot(held | (kedm_pkg::IN_W'(1) << k));
                else
                    send_snapshot(held);
                extra = $urandom_range(0, 2);
                repeat (extra) send_snapshot(held);
                if ($urandom_range(0, 4) == 0)
                    send_snapshot(held | (kedm_pkg::IN_W'(1) << k)
                                  | (kedm_pkg::IN_W'(1)
                                     << $urandom_range(0, kedm_pkg::IN_W - 1)));
                else
                    send_snapshot(held | (kedm_pkg::IN_W'(1) << k));
            end
            else if (pick < 85)
            begin
                w = {$urandom, $urandom};
                send_snapshot(w[kedm_pkg::IN_W-1:0]);
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0: send_snapshot('0);
                    1: send_snapshot(ALL_KEYS);
                    default: send_snapshot(kedm_pkg::IN_W'(1)
                                           << $urandom_range(0, kedm_pkg::IN_W - 1));
                endcase
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        keys_if.valid = 1'b0;
        keys_if.keys_down = '0;
        seen_up = '0;
        phase = PH_CAPTURE;
        shift_on = 1'b0;
        alpha_on = 1'b0;
        alpha_lock = 1'b0;
        shift_key = 6'd0;
        alpha_key = 6'd1;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_snapshot(dir_rows[i].keys, dir_rows[i].typed, dir_rows[i].ev);
        drain();

        // neither modifier maps to a real key
        set_modifier_keys(6'd63, 6'd63);
        run_random(120, 1'b0);
        drain();

        // shared key: shift wins; no idling here
        idle_on = 1'b0;
        set_modifier_keys(6'd5, 6'd5);
        run_random(120, 1'b0);
        drain();
        idle_on = 1'b1;

        set_modifier_keys(6'd45, 6'd0);
        run_random(150, 1'b1);
        drain();

        set_modifier_keys(6'd0, 6'd1);
        run_random(150, 1'b0);
        drain();

        repeat (2)
        begin
            set_modifier_keys(kedm_pkg::KEY_W'($urandom_range(0, 63)),
                              kedm_pkg::KEY_W'($urandom_range(0, 63)));
            run_random(150, 1'b0);
            drain();
        end

        for (int i = 0; i < 4000 && pending_events.size() != 0; i++)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (pending_events.size() != 0)
        begin
            fault_count++;
            $display("%0t ns: %0d key events never arrived", $time, pending_events.size());
        end
        if (fault_count == 0)
            $display("key_event_debounce_modifiers test passed");
        else
            $display("key_event_debounce_modifiers test failed");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("key_event_debounce_modifiers test failed");
        $finish;
    end

endmodule
